// File: sv/f2p_pkg.sv
// Package for the float to PCM converter: constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
package f2p_pkg;
   localparam logic [22:0] SCALE16 = 23'd32767;
   localparam logic [22:0] SCALE24 = 23'd8388607;
   localparam logic [0:0] CSR_SAMPLE_FORMAT = 1'd0;
   localparam logic [0:0] CSR_ATTEN_SHIFT   = 1'd1;
   localparam int CSR_DATA_W = 3;
   localparam logic [2:0] ATTEN_RESET = 3'd3;

   // Stage 1 to stage 2 carry: sign, clamp/zero flags, exponent, product.
   typedef struct packed {
      logic        sign;
      logic        force_full;
      logic        force_zero;
      logic [7:0]  expo;
      logic [46:0] prod;
   } s1_type;
endpackage

// File: sv/float_to_pcm_converter_top.sv
// Top level of the float to PCM converter: four-stage pipeline.
// Depends on f2p_pkg.
`timescale 1ns / 1ps
// Channel     Direction  Ports
// request     in         start, busy, req_sample_bits
// response    out        rsp_valid, rsp_pcm_value
// csr         in         csr_we, csr_index, csr_wdata
//
// One request enters every cycle; busy is held low. The result passes s1_ff,
// s2_ff, x_ff and rsp_pcm_value and leaves on rsp_valid for one cycle. The depth is
// set by the 24x23 multiply, the float rounding and the final shift stage.
// Reset (synchronous) clears the valid bits and restores the csr defaults.
// The receiver cannot stall, so the pipeline never holds.
module float_to_pcm_converter_top
   import f2p_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_sample_bits,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_pcm_value,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic       fmt_ff;
   logic [2:0] sh_ff;
   logic [3:0] v_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= 1'b0;
         sh_ff  <= ATTEN_RESET;
         v_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_FORMAT: fmt_ff <= csr_wdata[0];
               CSR_ATTEN_SHIFT:   sh_ff  <= csr_wdata;
               default: ;
            endcase
         end
         v_ff <= {v_ff[2:0], start};
      end
   end

   // Stage 1: decode and multiply the significand by the full scale.
   s1_type s1_in, s1_ff;
   always_comb begin
      logic [7:0]  e;
      logic [22:0] f;
      logic [23:0] m;
      e = req_sample_bits[30:23];
      f = req_sample_bits[22:0];
      m = (e == 8'd0) ? {1'b0, f} : {1'b1, f};
      s1_in.sign       = req_sample_bits[31];
      s1_in.force_zero = (e == 8'hFF) && (f != 23'd0);
      s1_in.force_full = (e >= 8'd127) && !s1_in.force_zero;
      s1_in.expo       = (e == 8'd0) ? 8'd1 : e;
      s1_in.prod       = {23'd0, m} * {24'd0, (fmt_ff ? SCALE24 : SCALE16)};
   end
   always_ff @(posedge clock) s1_ff <= s1_in;

   // Stage 2: round the product to 24 significant bits, nearest-even.
   logic [5:0]  len;
   logic [46:0] rq;
   always_comb begin
      logic [5:0]  d;
      logic [46:0] kept, rem, half;
      d    = '0;
      kept = '0;
      rem  = '0;
      half = '0;
      len = '0;
      for (int i = 0; i < 47; i++) if (s1_ff.prod[i]) len = 6'(i + 1);
      rq = s1_ff.prod;
      if (len > 6'd24) begin
         d    = len - 6'd24;
         kept = s1_ff.prod >> d;
         rem  = s1_ff.prod & ((47'd1 << d) - 47'd1);
         half = 47'd1 << (d - 6'd1);
         if (rem > half || (rem == half && kept[0])) kept = kept + 47'd1;
         rq = 47'(kept << d);
      end
   end
   s1_type s2_in, s2_ff;
   always_comb begin
      s2_in      = s1_ff;
      s2_in.prod = rq;
   end
   always_ff @(posedge clock) s2_ff <= s2_in;

   function automatic logic [23:0] fmtd_scale(input logic fm);
      return fm ? {1'b0, SCALE24} : {1'b0, SCALE16};
   endfunction

   // Stage 3: round to integer, ties away, apply sign and clamp.
   logic signed [24:0] x_in, x_ff;
   always_comb begin
      logic [7:0]  k;
      logic [47:0] t;
      logic [23:0] mag;
      k   = 8'd150 - s2_ff.expo;
      t   = {1'b0, s2_ff.prod} + (48'd1 << (k - 8'd1));
      mag = (k >= 8'd60) ? 24'd0 : 24'(t >> k);
      if (s2_ff.force_zero) mag = '0;
      else if (s2_ff.force_full) mag = fmtd_scale(fmt_ff);
      x_in = s2_ff.sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end
   always_ff @(posedge clock) x_ff <= x_in;

   // Stage 4: rounding arithmetic shift.
   logic signed [25:0] r;
   always_comb begin
      r = {x_ff[24], x_ff};
      if (sh_ff != 3'd0) r = r + (26'sd1 <<< (sh_ff - 3'd1));
      r = r >>> sh_ff;
   end
   always_ff @(posedge clock) rsp_pcm_value <= r[23:0];
   assign rsp_valid = v_ff[3];

   a_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start ##4 1 |-> rsp_valid) else $error("lost result");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      s2_ff.force_zero && v_ff[1] |=> x_ff == 25'sd0) else $error("nan nonzero");
endmodule
